@@ sv/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/skht_pkg.sv @@
// Shared types, constants and key folding for the string key hash table.
// No dependencies; compile first.
package skht_pkg;

  localparam int KindW     = 2;
  localparam int KeyW      = 64;
  localparam int ValW      = 32;
  localparam int StatW     = 2;
  localparam int LiveW     = 7;
  localparam int LimitW    = 7;
  localparam int KeyBytes  = 8;
  localparam int SLOTS_DEF = 64;

  localparam logic [LimitW-1:0] LimitReset = 7'd45;
  localparam logic [31:0]       FnvOffset  = 32'd2166136261;
  localparam logic [31:0]       FnvPrime   = 32'd16777619;

  typedef enum logic [KindW-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } skht_kind_t;

  typedef enum logic [StatW-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } skht_status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2
  } skht_mark_t;

  typedef struct packed {
    skht_mark_t             mark;
    logic [KeyW-1:0]        key;
    logic [ValW-1:0]        handler;
  } skht_slot_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HASH,
    ST_WALK,
    ST_DONE
  } skht_state_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_HASH,
    HS_MOD
  } skht_hash_st_t;

  // Keep bytes up to the first zero byte, fold A-Z to a-z, clear the rest.
  function automatic logic [KeyW-1:0] fold_key(input logic [KeyW-1:0] raw);
    logic [KeyW-1:0] k;
    logic            stop;
    logic [7:0]      b;
    k    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b = raw[8*i +: 8];
      if (i >= KeyBytes || b == 8'd0) stop = 1'b1;
      if (!stop) begin
        if (b >= 8'h41 && b <= 8'h5A) b = b + 8'h20;
        k[8*i +: 8] = b;
      end
    end
    return k;
  endfunction

endpackage

@@ sv/skht_chan_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on skht_pkg for field widths.
interface skht_in_if;
  import skht_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [KindW-1:0]       kind;
  logic [KeyW-1:0]        key_text;
  logic signed [ValW-1:0] handler_value;

  modport source (output valid, kind, key_text, handler_value, input ready);
  modport sink   (input valid, kind, key_text, handler_value, output ready);
endinterface

interface skht_out_if;
  import skht_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [StatW-1:0]       status;
  logic signed [ValW-1:0] found_value;
  logic [LiveW-1:0]       live_count;

  modport source (output valid, status, found_value, live_count, input ready);
  modport sink   (input valid, status, found_value, live_count, output ready);
endinterface

@@ sv/skht_hash.sv @@
// FNV-1a hash of a folded key, one byte per cycle, then reduction to a home slot.
// Depends on skht_pkg.
module skht_hash #(
  parameter int SLOTS = skht_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [skht_pkg::KeyW-1:0] key_i,
  output logic                      done_o,
  output logic [$clog2(SLOTS)-1:0]  home_o
);
  import skht_pkg::*;

  localparam int IdxW      = $clog2(SLOTS);
  localparam int RemW      = IdxW + 1;
  localparam bit SlotsPow2 = ((SLOTS & (SLOTS - 1)) == 0);

  skht_hash_st_t   hst_r, hst_nxt;
  logic [KeyW-1:0] key_sh_r, key_sh_nxt;
  logic [31:0]     hash_r, hash_nxt;
  logic [IdxW-1:0] rem_r, rem_nxt;
  logic [2:0]      mod_cnt_r, mod_cnt_nxt;
  logic            done_r, done_nxt;
  logic [IdxW-1:0] home_r, home_nxt;
  logic [31:0]     mix;
  logic [IdxW-1:0] rem_step;

  assign mix = (hash_r ^ {24'd0, key_sh_r[7:0]}) * FnvPrime;

  // Four restoring steps of hash mod SLOTS, most significant bits first.
  always_comb begin : mod_steps
    logic [RemW-1:0] t;
    logic [IdxW-1:0] r;
    r = rem_r;
    for (int j = 0; j < 4; j++) begin
      t = {r, hash_r[31-j]};
      if (t >= RemW'(SLOTS)) t = t - RemW'(SLOTS);
      r = t[IdxW-1:0];
    end
    rem_step = r;
  end

  always_comb begin : hash_next_state
    hst_nxt = hst_r;
    case (hst_r)
      HS_IDLE: if (start_i) hst_nxt = HS_HASH;
      HS_HASH: if (key_sh_r[7:0] == 8'd0) hst_nxt = SlotsPow2 ? HS_IDLE : HS_MOD;
      HS_MOD:  if (mod_cnt_r == 3'd7) hst_nxt = HS_IDLE;
      default: hst_nxt = HS_IDLE;
    endcase
  end

  always_comb begin : hash_datapath
    key_sh_nxt  = key_sh_r;
    hash_nxt    = hash_r;
    rem_nxt     = rem_r;
    mod_cnt_nxt = mod_cnt_r;
    home_nxt    = home_r;
    done_nxt    = 1'b0;
    case (hst_r)
      HS_IDLE: begin
        if (start_i) begin
          key_sh_nxt = key_i;
          hash_nxt   = FnvOffset;
        end
      end
      HS_HASH: begin
        // Folded key is zero after its last byte: stop at the first zero byte.
        if (key_sh_r[7:0] == 8'd0) begin
          if (SlotsPow2) begin
            done_nxt = 1'b1;
            home_nxt = hash_r[IdxW-1:0];
          end else begin
            rem_nxt     = '0;
            mod_cnt_nxt = 3'd0;
          end
        end else begin
          hash_nxt   = mix;
          key_sh_nxt = key_sh_r >> 8;
        end
      end
      HS_MOD: begin
        rem_nxt     = rem_step;
        hash_nxt    = hash_r << 4;
        mod_cnt_nxt = mod_cnt_r + 3'd1;
        if (mod_cnt_r == 3'd7) begin
          done_nxt = 1'b1;
          home_nxt = rem_step;
        end
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hst_r  <= HS_IDLE;
      done_r <= 1'b0;
    end else begin
      hst_r  <= hst_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_sh_r  <= key_sh_nxt;
    hash_r    <= hash_nxt;
    rem_r     <= rem_nxt;
    mod_cnt_r <= mod_cnt_nxt;
    home_r    <= home_nxt;
  end

  assign done_o = done_r;
  assign home_o = home_r;

endmodule

@@ sv/string_key_hash_table.sv @@
// String key hash table: top level with slot memory and probe sequencer.
// Depends on skht_pkg, skht_chan_if and skht_hash.
//
// Usage:
//   in_chan carries one request: kind (lookup, add, remove, clear), an ASCII
//   key of up to eight bytes and a handler id. out_chan returns one result per
//   request: status, found handler id and the live entry count.
//   cfg_wr_en/cfg_wr_data set the entry limit; write only while idle.
//   One request is in flight at a time; in_chan.ready is high when idle.
//   After accept the hash unit hashes the key one byte per cycle; a slot count that
//   is not a power of two adds a reduction of the hash to the home slot. The walk
//   then probes from the home slot, one slot memory read per cycle.
//   Clear rewrites every slot as empty, one per cycle.
//   After reset the same sweep runs before the first request is accepted;
//   configuration writes are taken during it.
//   The result sits in an output register: a new request is accepted while it
//   waits, and a finished request holds until the register is free.
module string_key_hash_table #(
  parameter int SLOTS = skht_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  skht_in_if.sink                     in_chan,
  skht_out_if.source                  out_chan,
  input  logic                        cfg_wr_en,
  input  logic [skht_pkg::LimitW-1:0] cfg_wr_data
);
  import skht_pkg::*;

  localparam int IdxW = $clog2(SLOTS);
  localparam int CntW = $clog2(SLOTS + 1);
  localparam int CmpW = (CntW > LimitW) ? CntW : LimitW;

  skht_state_t     state_r, state_nxt;
  skht_kind_t      kind_r, kind_nxt;
  logic [KeyW-1:0] key_r, key_nxt;
  logic [ValW-1:0] hval_r, hval_nxt;
  logic [CntW-1:0] occ_r, occ_nxt;
  logic [LimitW-1:0] limit_r, limit_nxt;
  logic [IdxW-1:0] probe_pos_r, probe_pos_nxt;
  logic [IdxW-1:0] probe_cnt_r, probe_cnt_nxt;
  logic            have_tomb_r, have_tomb_nxt;
  logic [IdxW-1:0] tomb_r, tomb_nxt;
  logic [IdxW-1:0] sweep_idx_r, sweep_idx_nxt;
  logic            sweep_rsp_r, sweep_rsp_nxt;
  skht_status_t    res_status_r, res_status_nxt;
  logic [ValW-1:0] res_found_r, res_found_nxt;
  logic            out_valid_r, out_valid_nxt;
  skht_status_t    out_status_r, out_status_nxt;
  logic [ValW-1:0] out_found_r, out_found_nxt;
  logic [LiveW-1:0] out_live_r, out_live_nxt;

  skht_slot_t      slot_mem [SLOTS];
  skht_slot_t      rd_data_r;
  logic            mem_rd_en;
  logic [IdxW-1:0] mem_rd_addr;
  logic            mem_wr_en;
  logic [IdxW-1:0] mem_wr_addr;
  skht_slot_t      mem_wr_data;

  logic            in_acc;
  logic [KeyW-1:0] key_fold;
  logic            hash_start;
  logic            hash_done;
  logic [IdxW-1:0] hash_home;
  logic [IdxW-1:0] pos_next;
  logic            out_free;

  // Walk decision for the slot read in this cycle.
  logic            wk_stop;
  logic            wk_wr;
  logic [IdxW-1:0] wk_addr;
  skht_slot_t      wk_slot;
  skht_status_t    wk_status;
  logic [ValW-1:0] wk_found;
  logic            wk_inc;
  logic            wk_dec;
  logic            wk_tomb_new;

  assign in_acc     = in_chan.valid && in_chan.ready;
  assign key_fold   = fold_key(in_chan.key_text);
  assign hash_start = in_acc && (skht_kind_t'(in_chan.kind) != KIND_CLEAR);
  assign pos_next   = (probe_pos_r == IdxW'(SLOTS - 1)) ? '0 : probe_pos_r + IdxW'(1);
  assign out_free   = !out_valid_r || out_chan.ready;

  skht_hash #(.SLOTS(SLOTS)) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (hash_start),
    .key_i   (key_fold),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  always_comb begin : walk_decide
    logic hit;
    logic last;
    logic room;
    logic ins_ok;
    hit  = (rd_data_r.mark == MARK_USED) && (rd_data_r.key == key_r);
    last = (probe_cnt_r == IdxW'(SLOTS - 1));
    room = CmpW'(occ_r) < CmpW'(limit_r);
    ins_ok      = 1'b0;
    wk_stop     = 1'b0;
    wk_wr       = 1'b0;
    wk_addr     = probe_pos_r;
    wk_slot     = '{mark: MARK_USED, key: key_r, handler: hval_r};
    wk_status   = STAT_OK;
    wk_found    = '0;
    wk_inc      = 1'b0;
    wk_dec      = 1'b0;
    wk_tomb_new = 1'b0;
    if (kind_r == KIND_ADD) begin
      if (hit) begin
        // Update in place, limit does not apply.
        wk_stop = 1'b1;
        wk_wr   = 1'b1;
      end else if (rd_data_r.mark == MARK_EMPTY || last) begin
        wk_stop = 1'b1;
        ins_ok  = (rd_data_r.mark == MARK_EMPTY) || (rd_data_r.mark == MARK_TOMB) ||
                  have_tomb_r;
        wk_addr = have_tomb_r ? tomb_r : probe_pos_r;
        if (ins_ok && room) begin
          wk_wr  = 1'b1;
          wk_inc = 1'b1;
        end else begin
          wk_status = STAT_FULL;
        end
      end else if (rd_data_r.mark == MARK_TOMB && !have_tomb_r) begin
        wk_tomb_new = 1'b1;
      end
    end else begin
      if (hit) begin
        wk_stop = 1'b1;
        if (kind_r == KIND_LOOKUP) begin
          wk_found = rd_data_r.handler;
        end else begin
          wk_wr   = 1'b1;
          wk_slot = '{mark: MARK_TOMB, key: rd_data_r.key, handler: rd_data_r.handler};
          wk_dec  = (occ_r != '0);
        end
      end else if (rd_data_r.mark == MARK_EMPTY || last) begin
        wk_stop   = 1'b1;
        wk_status = STAT_MISS;
      end
    end
  end

  always_comb begin : next_state
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sweep_idx_r == IdxW'(SLOTS - 1)) state_nxt = sweep_rsp_r ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (skht_kind_t'(in_chan.kind) == KIND_CLEAR) ? ST_SWEEP : ST_HASH;
        end
      end
      ST_HASH: if (hash_done) state_nxt = ST_WALK;
      ST_WALK: if (wk_stop) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin : datapath
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    hval_nxt       = hval_r;
    occ_nxt        = occ_r;
    limit_nxt      = cfg_wr_en ? cfg_wr_data : limit_r;
    probe_pos_nxt  = probe_pos_r;
    probe_cnt_nxt  = probe_cnt_r;
    have_tomb_nxt  = have_tomb_r;
    tomb_nxt       = tomb_r;
    sweep_idx_nxt  = sweep_idx_r;
    sweep_rsp_nxt  = sweep_rsp_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_live_nxt   = out_live_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = probe_pos_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = wk_addr;
    mem_wr_data    = wk_slot;
    case (state_r)
      ST_SWEEP: begin
        mem_wr_en     = 1'b1;
        mem_wr_addr   = sweep_idx_r;
        mem_wr_data   = '{mark: MARK_EMPTY, key: '0, handler: '0};
        sweep_idx_nxt = sweep_idx_r + IdxW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt = skht_kind_t'(in_chan.kind);
          key_nxt  = key_fold;
          hval_nxt = in_chan.handler_value;
          if (skht_kind_t'(in_chan.kind) == KIND_CLEAR) begin
            sweep_idx_nxt  = '0;
            sweep_rsp_nxt  = 1'b1;
            occ_nxt        = '0;
            res_status_nxt = STAT_OK;
            res_found_nxt  = '0;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          mem_rd_en     = 1'b1;
          mem_rd_addr   = hash_home;
          probe_pos_nxt = hash_home;
          probe_cnt_nxt = '0;
          have_tomb_nxt = 1'b0;
        end
      end
      ST_WALK: begin
        // Read the next slot ahead; drop it if this slot ends the walk.
        mem_rd_en   = 1'b1;
        mem_rd_addr = pos_next;
        mem_wr_en   = wk_wr;
        if (wk_stop) begin
          res_status_nxt = wk_status;
          res_found_nxt  = wk_found;
          if (wk_inc) occ_nxt = occ_r + CntW'(1);
          if (wk_dec) occ_nxt = occ_r - CntW'(1);
        end else begin
          probe_pos_nxt = pos_next;
          probe_cnt_nxt = probe_cnt_r + IdxW'(1);
          if (wk_tomb_new) begin
            have_tomb_nxt = 1'b1;
            tomb_nxt      = probe_pos_r;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_live_nxt   = LiveW'(occ_r);
        end
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      occ_r       <= '0;
      limit_r     <= LimitReset;
      sweep_idx_r <= '0;
      sweep_rsp_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      limit_r     <= limit_nxt;
      sweep_idx_r <= sweep_idx_nxt;
      sweep_rsp_r <= sweep_rsp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    hval_r       <= hval_nxt;
    probe_pos_r  <= probe_pos_nxt;
    probe_cnt_r  <= probe_cnt_nxt;
    have_tomb_r  <= have_tomb_nxt;
    tomb_r       <= tomb_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_live_r   <= out_live_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) slot_mem[mem_wr_addr] <= mem_wr_data;
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) rd_data_r <= slot_mem[mem_rd_addr];
  end

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.found_value = out_found_r;
  assign out_chan.live_count  = out_live_r;

endmodule

@@ sv/skht_checker.sv @@
// Port-level checks for the string key hash table, bound to the top level.
// Depends on skht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module skht_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [skht_pkg::StatW-1:0]   out_status,
  input logic [skht_pkg::ValW-1:0]    out_found,
  input logic [skht_pkg::LiveW-1:0]   out_live
);
  import skht_pkg::*;

  `ASSERT_ALWAYS(a_reset_no_result, clk, !rst_n |=> !out_valid, "result valid after reset")

  `ASSERT_RST(a_one_in_flight, clk, rst_n, in_valid && in_ready |=> !in_ready, "second request taken while busy")

  `ASSERT_RST(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_found) && $stable(out_live), "stalled result changed")

  `ASSERT_RST(a_found_zero, clk, rst_n, out_valid && (out_status != STAT_OK) |-> out_found == '0, "found value nonzero on failure")

endmodule

bind string_key_hash_table skht_checker u_skht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_found  (out_chan.found_value),
  .out_live   (out_chan.live_count)
);
